### design/rmq_pkg.sv
// Shared types and constants of the range-minimum query engine.
package rmq_pkg;

  localparam int CNT_W = 13;
  localparam int IDX_W = 12;
  localparam int DATA_W = 32;
  localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;
  localparam int SEG_LOG = 4;  // 16 elements per block-minimum entry

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_UNBUILT = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BRD,
    S_BACC,
    S_QRD,
    S_QACC,
    S_QFIN
  } state_t;

  // Register block to datapath: write strobe and raw count.
  typedef struct packed {
    logic             wr;
    logic [CNT_W-1:0] count;
  } cfg_stat_t;

endpackage

### design/rmq_if.sv
// Valid/ready channel interfaces for query items and results.
interface rmq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] element_index;
  logic [31:0] element_value;
  logic [11:0] range_start;
  logic [11:0] range_end;
  modport source (output valid, command, element_index, element_value, range_start,
                  range_end, input ready);
  modport sink (input valid, command, element_index, element_value, range_start,
                range_end, output ready);
endinterface

interface rmq_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] min_position;
  logic [31:0] min_value;
  logic [1:0]  status;
  modport source (output valid, min_position, min_value, status, input ready);
  modport sink (input valid, min_position, min_value, status, output ready);
endinterface

### design/range_minimum_query_engine.sv
// Range-minimum query engine: element store, block-minimum store and sequencer.
//
// Usage: load elements with command 0 on the in_ch channel, then issue a
// build (command 1), then queries (command 2). Each query yields one
// transfer on out_ch with the leftmost minimum position, its value and a
// status; loads and builds yield nothing. element_count must be set over
// the APB port only while the block is idle; the block does not enforce
// this. Writing it invalidates the tables. A load is written to the
// element store as it is accepted. A build walks the element store one
// element at a time through a read and an accumulate state, writing one
// minimum per block of 16. A query visits up to 15 single elements at
// each end of the range plus one block-minimum read per full block, each
// through a read and an accumulate state; errors go to the result state.
// One item is in work at a time; in_ch.ready is high only when idle.
// After reset the tables count as unbuilt and the count is 4096; the
// stores hold nothing meaningful until written. If the receiver stalls,
// the result is held in the output register; the next transfer is still
// taken, and a further result waits in the sequencer until it leaves.
module range_minimum_query_engine #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  rmq_in_if.sink      in_ch,
  rmq_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rmq_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int PW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int NB = MAX_ELEMENTS / 16;
  localparam int BW = $clog2(NB);
  localparam logic [SEG_LOG-1:0] SEG_LAST = '1;

  cfg_stat_t cstat;

  rmq_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .stat(cstat)
  );

  // effective count, clamped to 1..MAX_ELEMENTS
  logic [PW-1:0] eff;
  always_comb begin
    if (cstat.count == '0) begin
      eff = PW'(1);
    end else if (32'(cstat.count) > MAX_ELEMENTS) begin
      eff = PW'(MAX_ELEMENTS);
    end else begin
      eff = PW'(cstat.count);
    end
  end

  state_t state_r, state_nxt;
  logic [PW-1:0]          ptr_r, ptr_nxt;
  logic [PW-1:0]          hi_r, hi_nxt;
  logic [VALUE_WIDTH-1:0] best_val_r, best_val_nxt;
  logic [AW-1:0]          best_pos_r, best_pos_nxt;
  logic [VALUE_WIDTH-1:0] blk_val_r, blk_val_nxt;
  logic [AW-1:0]          blk_pos_r, blk_pos_nxt;
  status_t                st_r, st_nxt;
  logic                   built_r, built_nxt;
  logic                   ov_r, ov_nxt;
  logic [IDX_W-1:0]       o_pos_r, o_pos_nxt;
  logic [DATA_W-1:0]      o_val_r, o_val_nxt;
  status_t                o_st_r, o_st_nxt;

  logic                   acc;
  cmd_t                   cmd;
  logic [PW-1:0]          lo_x, hi_x, idx_x;
  logic [VALUE_WIDTH-1:0] vdata;
  logic [VALUE_WIDTH+AW-1:0] bdata;
  logic                   v_we, b_we;
  logic [VALUE_WIDTH+AW-1:0] b_wdata;
  logic                   seg_end, use_blk, take;
  logic [VALUE_WIDTH-1:0] cand_val;
  logic [AW-1:0]          cand_pos;
  logic [PW-1:0]          step_ptr;
  logic                   out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc   = in_ch.valid && in_ch.ready;
  assign cmd   = cmd_t'(in_ch.command);
  assign lo_x  = PW'(in_ch.range_start);
  assign hi_x  = PW'(in_ch.range_end);
  assign idx_x = PW'(in_ch.element_index);
  assign out_free = !ov_r || out_ch.ready;

  // element store: written by loads, read at the scan pointer
  assign v_we = acc && (cmd == CMD_LOAD) && (idx_x < eff);

  rmq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ELEMENTS)) u_vals (
    .clk,
    .we(v_we),
    .waddr(AW'(in_ch.element_index)),
    .wdata(VALUE_WIDTH'(in_ch.element_value)),
    .raddr(ptr_r[AW-1:0]),
    .rdata(vdata)
  );

  // block-minimum store: value and leftmost position per 16 elements
  rmq_ram #(.WIDTH(VALUE_WIDTH + AW), .DEPTH(NB)) u_blks (
    .clk,
    .we(b_we),
    .waddr(ptr_r[AW-1:SEG_LOG]),
    .wdata(b_wdata),
    .raddr(ptr_r[AW-1:SEG_LOG]),
    .rdata(bdata)
  );

  // build: running minimum within the current block
  assign seg_end = (ptr_r[SEG_LOG-1:0] == SEG_LAST) || (ptr_r == eff - PW'(1));
  always_comb begin
    if ((ptr_r[SEG_LOG-1:0] == '0) || (vdata < blk_val_r)) begin
      cand_val = vdata;
      cand_pos = ptr_r[AW-1:0];
    end else begin
      cand_val = blk_val_r;
      cand_pos = blk_pos_r;
    end
  end
  assign b_we    = (state_r == S_BACC) && seg_end;
  assign b_wdata = {cand_val, cand_pos};

  // query: a whole block is taken when aligned and inside the range
  assign use_blk  = (ptr_r[SEG_LOG-1:0] == '0) && (ptr_r + PW'(15) <= hi_r);
  assign step_ptr = ptr_r + (use_blk ? PW'(16) : PW'(1));
  assign take     = use_blk ? (bdata[VALUE_WIDTH+AW-1:AW] < best_val_r)
                            : (vdata < best_val_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && cmd == CMD_BUILD) begin
          state_nxt = S_BRD;
        end else if (acc && cmd == CMD_QUERY) begin
          if (!built_r || lo_x > hi_x || hi_x >= eff) begin
            state_nxt = S_QFIN;
          end else begin
            state_nxt = S_QRD;
          end
        end
      end
      S_BRD:  state_nxt = S_BACC;
      S_BACC: state_nxt = (ptr_r == eff - PW'(1)) ? S_IDLE : S_BRD;
      S_QRD:  state_nxt = S_QACC;
      S_QACC: state_nxt = (step_ptr > hi_r) ? S_QFIN : S_QRD;
      S_QFIN: state_nxt = out_free ? S_IDLE : S_QFIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ptr_nxt      = ptr_r;
    hi_nxt       = hi_r;
    best_val_nxt = best_val_r;
    best_pos_nxt = best_pos_r;
    blk_val_nxt  = blk_val_r;
    blk_pos_nxt  = blk_pos_r;
    st_nxt       = st_r;
    built_nxt    = built_r;
    ov_nxt       = ov_r && !out_ch.ready;
    o_pos_nxt    = o_pos_r;
    o_val_nxt    = o_val_r;
    o_st_nxt     = o_st_r;
    if (cstat.wr || v_we) begin
      built_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (acc && cmd == CMD_BUILD) begin
          ptr_nxt = '0;
        end else if (acc && cmd == CMD_QUERY) begin
          ptr_nxt      = lo_x;
          hi_nxt       = hi_x;
          best_val_nxt = '1;
          best_pos_nxt = AW'(in_ch.range_start);
          if (!built_r) begin
            st_nxt = ST_UNBUILT;
          end else if (lo_x > hi_x || hi_x >= eff) begin
            st_nxt = ST_RANGE;
          end else begin
            st_nxt = ST_OK;
          end
        end
      end
      S_BRD: ;
      S_BACC: begin
        blk_val_nxt = cand_val;
        blk_pos_nxt = cand_pos;
        ptr_nxt     = ptr_r + PW'(1);
        if (ptr_r == eff - PW'(1)) begin
          built_nxt = 1'b1;
        end
      end
      S_QRD: ;
      S_QACC: begin
        ptr_nxt = step_ptr;
        if (take) begin
          best_val_nxt = use_blk ? bdata[VALUE_WIDTH+AW-1:AW] : vdata;
          best_pos_nxt = use_blk ? bdata[AW-1:0] : ptr_r[AW-1:0];
        end
      end
      S_QFIN: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          o_st_nxt = st_r;
          if (st_r == ST_OK) begin
            o_pos_nxt = IDX_W'(best_pos_r);
            o_val_nxt = DATA_W'(best_val_r);
          end else begin
            o_pos_nxt = '0;
            o_val_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      built_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      built_r <= built_nxt;
      ov_r    <= ov_nxt;
    end
    ptr_r      <= ptr_nxt;
    hi_r       <= hi_nxt;
    best_val_r <= best_val_nxt;
    best_pos_r <= best_pos_nxt;
    blk_val_r  <= blk_val_nxt;
    blk_pos_r  <= blk_pos_nxt;
    st_r       <= st_nxt;
    o_pos_r    <= o_pos_nxt;
    o_val_r    <= o_val_nxt;
    o_st_r     <= o_st_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.min_position = o_pos_r;
  assign out_ch.min_value    = o_val_r;
  assign out_ch.status       = o_st_r;
endmodule

### design/rmq_ram.sv
// Generic synchronous RAM: one write port, one registered read port.
module rmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/rmq_cfg.sv
// APB register block holding the element count.
module rmq_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rmq_pkg::cfg_stat_t  stat
);
  import rmq_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic             wr;

  // single register, every address decodes to it
  assign wr = psel && penable && pwrite && (paddr == 2'd0 || paddr != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (wr) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign pready     = 1'b1;
  assign prdata     = {{(32-CNT_W){1'b0}}, count_r};
  assign stat.wr    = wr;
  assign stat.count = count_r;
endmodule

### design/rmq_checker.sv
// Port-level checks of the range-minimum query engine, bound to the top level.
module rmq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_pos,
  input logic [31:0] out_val,
  input logic [1:0]  out_status
);
  import rmq_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // failed queries carry a zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_pos == '0 && out_val == '0)
    else $error("error result with non-zero payload");

  // a new result only follows a busy cycle of the input side
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while input side idle");
endmodule

bind range_minimum_query_engine rmq_checker u_rmq_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_pos(out_ch.min_position),
  .out_val(out_ch.min_value),
  .out_status(out_ch.status)
);
